FILE: rtl/core/sha2_pkg.sv
// Shared types, constants and tables for the SHA-2 hash engine.
// Used by sha2_ctrl, sha2_dpath and sha2_hash_engine; no dependencies.
package sha2_pkg;

    // mode register codes
    localparam logic [1:0] MODE_224 = 2'd0;
    localparam logic [1:0] MODE_256 = 2'd1;
    localparam logic [1:0] MODE_384 = 2'd2;
    localparam logic [1:0] MODE_512 = 2'd3;

    localparam int NumRoundsS = 64;
    localparam int NumRoundsL = 80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } msg_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        word_last;
    } dig_t;

    // controller to datapath commands
    typedef struct packed {
        logic       write_byte;
        logic       restart;
        logic       load;
        logic       round;
        logic       addh;
        logic       pad;
        logic       len;
        logic [6:0] rnd;
        logic [2:0] word_idx;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic       wide;
        logic       blk_end;
        logic       overflow;
        logic [1:0] mode;
    } sts_t;

    localparam logic [63:0] IV_TAB [4][8] = '{
        '{64'hc1059ed8, 64'h367cd507, 64'h3070dd17, 64'hf70e5939,
          64'hffc00b31, 64'h68581511, 64'h64f98fa7, 64'hbefa4fa4},
        '{64'h6a09e667, 64'hbb67ae85, 64'h3c6ef372, 64'ha54ff53a,
          64'h510e527f, 64'h9b05688c, 64'h1f83d9ab, 64'h5be0cd19},
        '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
          64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
          64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4},
        '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
          64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
          64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179}
    };

    // 64-bit round constants; the 32-bit modes use the upper halves
    localparam logic [63:0] K_TAB [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // index of the final digest word for a mode
    function automatic logic [2:0] last_word(input logic [1:0] mode);
        logic [2:0] r;
        case (mode)
            MODE_224: r = 3'd6;
            MODE_256: r = 3'd7;
            MODE_384: r = 3'd5;
            MODE_512: r = 3'd7;
            default:  r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/sha2_ctrl.sv
// Sequencer for the SHA-2 hash engine: byte intake, rounds, padding, digest output.
// Depends on sha2_pkg; drives sha2_dpath through cmd_t and reads sts_t.
module sha2_ctrl
    import sha2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic msg_valid,
    input  msg_t msg,
    output logic msg_stall,
    output logic dig_valid,
    input  logic dig_stall,
    output logic word_last,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADDH  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_LEN   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // what follows a compression
    localparam logic [1:0] PH_MSG = 2'd0;
    localparam logic [1:0] PH_PAD = 2'd1;
    localparam logic [1:0] PH_LEN = 2'd2;
    localparam logic [1:0] PH_OUT = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       msg_acc, dig_acc, rnd_end;

    assign msg_stall = (state_reg != ST_IDLE);
    assign dig_valid = (state_reg == ST_OUT);
    assign msg_acc   = msg_valid && !msg_stall;
    assign dig_acc   = dig_valid && !dig_stall;
    assign word_last = (idx_reg == last_word(sts.mode));
    assign rnd_end   = sts.wide ? (rnd_reg == 7'(NumRoundsL - 1))
                                : (rnd_reg == 7'(NumRoundsS - 1));

    // sequence next state and commands
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.rnd      = rnd_reg;
        cmd.word_idx = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc)
                begin
                    cmd.write_byte = msg.byte_valid;
                    if (msg.byte_valid && sts.blk_end)
                    begin
                        state_next = ST_LOAD;
                        phase_next = msg.last ? PH_PAD : PH_MSG;
                    end
                    else if (msg.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_end ? 7'd0 : rnd_reg + 7'd1;
                if (rnd_end)
                begin
                    state_next = ST_ADDH;
                end
            end
            ST_ADDH:
            begin
                cmd.addh = 1'b1;
                case (phase_reg)
                    PH_MSG:  state_next = ST_IDLE;
                    PH_PAD:  state_next = ST_PAD;
                    PH_LEN:  state_next = ST_LEN;
                    PH_OUT:  state_next = ST_OUT;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_PAD:
            begin
                cmd.pad    = 1'b1;
                phase_next = sts.overflow ? PH_LEN : PH_OUT;
                state_next = ST_LOAD;
            end
            ST_LEN:
            begin
                cmd.len    = 1'b1;
                phase_next = PH_OUT;
                state_next = ST_LOAD;
            end
            ST_OUT:
            begin
                if (dig_acc)
                begin
                    if (word_last)
                    begin
                        cmd.restart = 1'b1;
                        idx_next    = '0;
                        phase_next  = PH_MSG;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_MSG;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: rtl/core/sha2_dpath.sv
// Datapath of the SHA-2 hash engine: mode, byte count, block buffer, schedule, round unit.
// Depends on sha2_pkg; commanded by sha2_ctrl.
module sha2_dpath
    import sha2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mode_we,
    input  logic [1:0]  mode_wdata,
    input  logic [7:0]  data_byte,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [63:0] digest_word
);

    logic [1:0]  mode_reg;
    logic [63:0] count_reg;
    logic [63:0] buf_reg [16];
    logic [63:0] w_reg [16];
    logic [63:0] v_reg [8];
    logic [63:0] h_reg [8];

    logic        wide;
    logic [6:0]  pos;
    logic [63:0] bits;
    logic [63:0] kw;
    logic [63:0] pad_word [16];
    logic [63:0] v_new [8];
    logic [63:0] w_new;

    function automatic logic [31:0] rs(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [63:0] rl(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    assign wide         = mode_reg[1];
    assign pos          = wide ? count_reg[6:0] : {1'b0, count_reg[5:0]};
    assign bits         = {count_reg[60:0], 3'b000};
    assign kw           = K_TAB[cmd.rnd];
    assign sts.wide     = wide;
    assign sts.mode     = mode_reg;
    assign sts.blk_end  = wide ? (pos == 7'd127) : (pos == 7'd63);
    assign sts.overflow = wide ? (pos >= 7'd112) : (pos >= 7'd56);
    assign digest_word  = h_reg[cmd.word_idx];

    // build padded block: keep bytes before pos, marker at pos, zeros after (length is set on store)
    always_comb
    begin
        logic [6:0] b;
        for (int k = 0; k < 16; k++)
        begin
            pad_word[k] = '0;
            for (int j = 0; j < 8; j++)
            begin
                b = wide ? 7'(8 * k + j) : 7'(4 * k + j);
                if (wide || j < 4)
                begin
                    if (b < pos)
                        pad_word[k][(wide ? 7 - j : 3 - j) * 8 +: 8] =
                            buf_reg[k][(wide ? 7 - j : 3 - j) * 8 +: 8];
                    else if (b == pos)
                        pad_word[k][(wide ? 7 - j : 3 - j) * 8 +: 8] = 8'h80;
                end
            end
        end
    end

    // one round and one schedule step, both widths
    always_comb
    begin
        logic [31:0] t1s, t2s, ws;
        logic [63:0] t1l, t2l, wl;
        t1s = v_reg[7][31:0]
            + (rs(v_reg[4][31:0], 6) ^ rs(v_reg[4][31:0], 11) ^ rs(v_reg[4][31:0], 25))
            + ((v_reg[4][31:0] & v_reg[5][31:0]) ^ (~v_reg[4][31:0] & v_reg[6][31:0]))
            + kw[63:32] + w_reg[0][31:0];
        t2s = (rs(v_reg[0][31:0], 2) ^ rs(v_reg[0][31:0], 13) ^ rs(v_reg[0][31:0], 22))
            + ((v_reg[0][31:0] & v_reg[1][31:0]) ^ (v_reg[0][31:0] & v_reg[2][31:0])
               ^ (v_reg[1][31:0] & v_reg[2][31:0]));
        t1l = v_reg[7] + (rl(v_reg[4], 14) ^ rl(v_reg[4], 18) ^ rl(v_reg[4], 41))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + kw + w_reg[0];
        t2l = (rl(v_reg[0], 28) ^ rl(v_reg[0], 34) ^ rl(v_reg[0], 39))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        ws = (rs(w_reg[14][31:0], 17) ^ rs(w_reg[14][31:0], 19) ^ (w_reg[14][31:0] >> 10))
           + w_reg[9][31:0]
           + (rs(w_reg[1][31:0], 7) ^ rs(w_reg[1][31:0], 18) ^ (w_reg[1][31:0] >> 3))
           + w_reg[0][31:0];
        wl = (rl(w_reg[14], 19) ^ rl(w_reg[14], 61) ^ (w_reg[14] >> 6)) + w_reg[9]
           + (rl(w_reg[1], 1) ^ rl(w_reg[1], 8) ^ (w_reg[1] >> 7)) + w_reg[0];
        w_new    = wide ? wl : {32'b0, ws};
        v_new[0] = wide ? (t1l + t2l) : {32'b0, t1s + t2s};
        v_new[1] = v_reg[0];
        v_new[2] = v_reg[1];
        v_new[3] = v_reg[2];
        v_new[4] = wide ? (v_reg[3] + t1l) : {32'b0, v_reg[3][31:0] + t1s};
        v_new[5] = v_reg[4];
        v_new[6] = v_reg[5];
        v_new[7] = v_reg[6];
    end

    // mode, count, buffer and chain value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_256;
            count_reg <= '0;
            for (int i = 0; i < 16; i++)
                buf_reg[i] <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= IV_TAB[MODE_256][i];
        end
        else if (mode_we)
        begin
            mode_reg  <= mode_wdata;
            count_reg <= '0;
            for (int i = 0; i < 16; i++)
                buf_reg[i] <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= IV_TAB[mode_wdata][i];
        end
        else if (cmd.restart)
        begin
            count_reg <= '0;
            for (int i = 0; i < 16; i++)
                buf_reg[i] <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= IV_TAB[mode_reg][i];
        end
        else
        begin
            if (cmd.write_byte)
            begin
                count_reg <= count_reg + 64'd1;
                if (wide)
                    buf_reg[pos[6:3]][(7 - pos[2:0]) * 8 +: 8] <= data_byte;
                else
                    buf_reg[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= data_byte;
            end
            if (cmd.pad)
            begin
                for (int i = 0; i < 14; i++)
                    buf_reg[i] <= pad_word[i];
                if (sts.overflow)
                begin
                    buf_reg[14] <= pad_word[14];
                    buf_reg[15] <= pad_word[15];
                end
                else
                begin
                    buf_reg[14] <= wide ? 64'd0 : {32'b0, bits[63:32]};
                    buf_reg[15] <= wide ? bits : {32'b0, bits[31:0]};
                end
            end
            if (cmd.len)
            begin
                for (int i = 0; i < 14; i++)
                    buf_reg[i] <= '0;
                buf_reg[14] <= wide ? 64'd0 : {32'b0, bits[63:32]};
                buf_reg[15] <= wide ? bits : {32'b0, bits[31:0]};
            end
            if (cmd.addh)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= wide ? (h_reg[i] + v_reg[i])
                                     : {32'b0, h_reg[i][31:0] + v_reg[i][31:0]};
            end
        end
    end

    // load and advance working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= buf_reg[i];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            for (int i = 0; i < 8; i++)
                v_reg[i] <= v_new[i];
        end
    end

endmodule

FILE: rtl/core/sha2_hash_engine.sv
// SHA-2 (224/256/384/512) hash engine, one message byte per beat.
// A byte that fills a block starts a compression: load, one round per cycle, chain update;
// input stalls until the chain update is done.
// A last beat pads and compresses once or twice, then emits 6 to 8 digest beats.
// Reset (async, active low) gives SHA-256, a mode write its mode; both start a fresh message.
module sha2_hash_engine
    import sha2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_we,
    input  logic [1:0] mode_wdata,
    input  logic       msg_valid,
    output logic       msg_stall,
    input  msg_t       msg,
    output logic       dig_valid,
    input  logic       dig_stall,
    output dig_t       dig
);

    cmd_t cmd;
    sts_t sts;
    logic word_last;
    logic [63:0] digest_word;

    sha2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg       (msg),
        .msg_stall (msg_stall),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .word_last (word_last),
        .sts       (sts),
        .cmd       (cmd)
    );

    sha2_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode_we     (mode_we),
        .mode_wdata  (mode_wdata),
        .data_byte   (msg.data_byte),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (digest_word)
    );

    assign dig.digest_word = digest_word;
    assign dig.word_last   = word_last;

`ifndef SYNTHESIS
    // no byte intake while digest beats are pending
    assert property (@(posedge clk) disable iff (!rst_n) dig_valid |-> msg_stall)
        else $error("input taken during digest output");
    // final digest beat ends the output burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && dig.word_last) |=> !dig_valid)
        else $error("digest output continues after final word");
    // 32-bit modes keep upper digest bits clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !sts.wide) |-> (dig.digest_word[63:32] == 32'd0))
        else $error("upper digest bits set in 32-bit mode");
`endif

endmodule
